// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the motor enable sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising clock edge, skipped while reset is held.
`define MSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on each rising clock edge, reset included.
`define MSQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/msq_pkg.sv -----
// Types, constants and codes of the motor enable sequencer.
package msq_pkg;

    // Event codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_THROTTLE = 2'd0,
        OP_DIGITAL  = 2'd1,
        OP_STATUS   = 2'd2,
        OP_TICK     = 2'd3
    } t_opcode;

    // Power-up and shutdown sequence steps
    typedef enum logic [3:0] {
        SEQ_IDLE      = 4'd0,
        SEQ_POWER     = 4'd1,
        SEQ_WAIT_DIS  = 4'd2,
        SEQ_WAIT_STBY = 4'd3,
        SEQ_WAIT_EN   = 4'd4,
        SEQ_RUN       = 4'd5,
        SEQ_STOP      = 4'd6,
        SEQ_STOP_STBY = 4'd7,
        SEQ_STOP_DIS  = 4'd8
    } t_seq_step;

    // Controller modes requested
    localparam logic [1:0] MODE_DISABLED = 2'd0;
    localparam logic [1:0] MODE_STANDBY  = 2'd1;
    localparam logic [1:0] MODE_ENABLED  = 2'd2;

    // Gear selections
    localparam logic [1:0] GEAR_NEUTRAL = 2'd0;
    localparam logic [1:0] GEAR_FORWARD = 2'd1;
    localparam logic [1:0] GEAR_REVERSE = 2'd2;

    // Digital-input command words
    localparam logic [15:0] DI_FORWARD  = 16'h00F0;
    localparam logic [15:0] DI_REVERSE  = 16'h0030;
    localparam logic [15:0] DI_NEUTRAL  = 16'h0000;
    localparam logic [15:0] DI_SHUTDOWN = 16'h0F00;

    // Command frame offsets
    localparam logic [15:0] SPEED_OFFSET = 16'd20000;
    localparam logic [15:0] TORQUE_MID   = 16'h7530;

    // Counter limits, reset values and step sizes
    localparam logic [7:0]  RAMP_MAX     = 8'hFF;
    localparam logic [11:0] FRAME_MAX    = 12'hFFF;
    localparam logic [3:0]  STATUS_OFF   = 4'hF;
    localparam logic [3:0]  ALIVE_STEP   = 4'd2;
    localparam logic [10:0] SPEED_STEP   = 11'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_RAMP_INTERVAL  = 3'd0;
    localparam logic [2:0] REG_FRAME_INTERVAL = 3'd1;
    localparam logic [2:0] REG_THROTTLE_LIMIT = 3'd2;
    localparam logic [2:0] REG_DRIVE_TORQUE   = 3'd3;
    localparam logic [2:0] REG_CODE_DISABLED  = 3'd4;
    localparam logic [2:0] REG_CODE_STANDBY   = 3'd5;
    localparam logic [2:0] REG_CODE_ENABLED   = 3'd6;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  ramp_interval;
        logic [11:0] frame_interval;
        logic [10:0] throttle_limit;
        logic [14:0] drive_torque;
        logic [3:0]  code_disabled;
        logic [3:0]  code_standby;
        logic [3:0]  code_enabled;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        ramp_interval:  8'd3,
        frame_interval: 12'd201,
        throttle_limit: 11'd1100,
        drive_torque:   15'd1000,
        code_disabled:  4'd1,
        code_standby:   4'd2,
        code_enabled:   4'd3
    };

    // Sequencer state kept between items
    typedef struct packed {
        t_seq_step   step;
        logic [1:0]  mode;
        logic [1:0]  gear;
        logic [14:0] torque;
        logic [10:0] req_speed;
        logic [10:0] speed;
        logic [3:0]  status;
        logic [7:0]  ramp_elapsed;
        logic [11:0] frame_elapsed;
        logic [3:0]  heartbeat;
        logic        supply_on;
    } t_state;

    localparam t_state STATE_RESET = '{
        step:          SEQ_IDLE,
        mode:          MODE_DISABLED,
        gear:          GEAR_NEUTRAL,
        torque:        15'd0,
        req_speed:     11'd0,
        speed:         11'd0,
        status:        STATUS_OFF,
        ramp_elapsed:  RAMP_MAX,
        frame_elapsed: 12'd0,
        heartbeat:     4'd0,
        supply_on:     1'b0
    };

    // One result item
    typedef struct packed {
        logic [3:0]  alive_count;
        logic [15:0] torque_lower_word;
        logic [15:0] torque_upper_word;
        logic [15:0] speed_word;
        logic        enable_pulse;
        logic        power_on;
        logic [10:0] ramped_speed;
        logic [14:0] commanded_torque;
        logic [1:0]  commanded_gear;
        logic [1:0]  commanded_state;
        logic [3:0]  sequence_step;
    } t_result;

endpackage

// ----- rtl/motor_enable_sequencer_with_ramp_core.sv -----
// Top level of the motor enable sequencer with speed ramp and command frame.
//
// One event item is taken per clock: the state update, the sequencer step,
// the frame check and the ramp step are all settled in the cycle the item is
// accepted, and its result item sits in the output register from the next
// cycle on. Throughput is one item per cycle; the only thing that holds the
// input is a result still waiting in the output register while the sink
// keeps o_m_axis_tvalid unanswered. Configuration writes take effect on the
// next item and are always accepted.
`include "assert_macros.svh"

module motor_enable_sequencer_with_ramp_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Event input
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] throttle_byte, [23:8] di_word, [27:24] status_code, [31:28] zero
    input  logic [31:0] i_s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  i_s_axis_tuser,
    // Result output
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [3:0] sequence_step, [5:4] commanded_state, [7:6] commanded_gear,
    // [22:8] commanded_torque, [33:23] ramped_speed, [34] power_on,
    // [35] enable_pulse, [51:36] speed_word, [67:52] torque_upper_word,
    // [83:68] torque_lower_word, [87:84] alive_count
    output logic [87:0] o_m_axis_tdata,
    // [0] frame_due
    output logic [0:0]  o_m_axis_tuser,
    // Configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [14:0] i_cfg_data
);

    msq_pkg::t_cfg    r_cfg;
    msq_pkg::t_cfg    n_cfg;
    msq_pkg::t_state  r_state;
    msq_pkg::t_state  step_state;
    msq_pkg::t_result step_result;
    logic             step_due;
    msq_pkg::t_result r_result;
    logic             r_frame_due;
    logic             r_out_valid;
    logic             in_accept;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // Decode configuration writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_addr)
                msq_pkg::REG_RAMP_INTERVAL:  n_cfg.ramp_interval  = i_cfg_data[7:0];
                msq_pkg::REG_FRAME_INTERVAL: n_cfg.frame_interval = i_cfg_data[11:0];
                msq_pkg::REG_THROTTLE_LIMIT: n_cfg.throttle_limit = i_cfg_data[10:0];
                msq_pkg::REG_DRIVE_TORQUE:   n_cfg.drive_torque   = i_cfg_data[14:0];
                msq_pkg::REG_CODE_DISABLED:  n_cfg.code_disabled  = i_cfg_data[3:0];
                msq_pkg::REG_CODE_STANDBY:   n_cfg.code_standby   = i_cfg_data[3:0];
                msq_pkg::REG_CODE_ENABLED:   n_cfg.code_enabled   = i_cfg_data[3:0];
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= msq_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Work out one event
    msq_step u_step (
        .i_state         (r_state),
        .i_cfg           (r_cfg),
        .i_opcode        (msq_pkg::t_opcode'(i_s_axis_tuser)),
        .i_throttle_byte (i_s_axis_tdata[7:0]),
        .i_di_word       (i_s_axis_tdata[23:8]),
        .i_status_code   (i_s_axis_tdata[27:24]),
        .o_state         (step_state),
        .o_result        (step_result),
        .o_frame_due     (step_due)
    );

    // Advance the state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msq_pkg::STATE_RESET;
        end else if (in_accept) begin
            r_state <= step_state;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result    <= step_result;
            r_frame_due <= step_due;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_result;
    assign o_m_axis_tuser[0] = r_frame_due;

    `MSQ_ASSERT(a_accept_gives_result, i_clk, i_rst_n, in_accept |=> r_out_valid, "accepted item left no result")
    `MSQ_ASSERT(a_pulse_with_power, i_clk, i_rst_n, (r_out_valid && r_result.enable_pulse) |-> r_result.power_on, "enable pulse without supply")
    `MSQ_ASSERT(a_idle_frame_zero, i_clk, i_rst_n, (r_out_valid && !r_frame_due) |-> (r_result.speed_word == 16'd0 && r_result.alive_count == 4'd0), "frame words set with no frame due")
    `MSQ_ASSERT(a_supply_off_at_idle, i_clk, i_rst_n, $fell(r_state.supply_on) |-> (r_state.step == msq_pkg::SEQ_IDLE), "supply dropped outside shutdown end")
    `MSQ_ASSERT(a_alive_even, i_clk, i_rst_n, !r_state.heartbeat[0], "heartbeat lost even value")

endmodule

// ----- rtl/msq_step.sv -----
// Next-state and result logic for one event of the motor enable sequencer.
module msq_step (
    input  msq_pkg::t_state  i_state,
    input  msq_pkg::t_cfg    i_cfg,
    input  msq_pkg::t_opcode i_opcode,
    input  logic [7:0]       i_throttle_byte,
    input  logic [15:0]      i_di_word,
    input  logic [3:0]       i_status_code,
    output msq_pkg::t_state  o_state,
    output msq_pkg::t_result o_result,
    output logic             o_frame_due
);

    msq_pkg::t_state   ev;
    msq_pkg::t_seq_step seq_next;
    logic [1:0]        mode_next;
    logic              supply_next;
    logic              pulse;
    logic [10:0]       throttle_req;
    logic              frame_due;
    logic [11:0]       frame_next;
    logic [3:0]        heartbeat_next;
    logic [10:0]       speed_next;
    logic [7:0]        ramp_next;
    logic              ramp_open;
    logic              ramp_up;
    logic              ramp_down;

    assign throttle_req = {1'b0, i_throttle_byte, 2'b00};

    // Apply the event to the state
    always_comb begin
        ev = i_state;
        case (i_opcode)
            msq_pkg::OP_THROTTLE: begin
                if (throttle_req < i_cfg.throttle_limit) begin
                    ev.req_speed = throttle_req;
                end
            end
            msq_pkg::OP_DIGITAL: begin
                if (i_di_word == msq_pkg::DI_FORWARD || i_di_word == msq_pkg::DI_REVERSE) begin
                    if (i_state.step == msq_pkg::SEQ_IDLE) begin
                        ev.step = msq_pkg::SEQ_POWER;
                    end else if (i_state.step == msq_pkg::SEQ_WAIT_EN) begin
                        ev.gear   = (i_di_word == msq_pkg::DI_FORWARD) ?
                                    msq_pkg::GEAR_FORWARD : msq_pkg::GEAR_REVERSE;
                        ev.torque = i_cfg.drive_torque;
                    end
                end else if (i_di_word == msq_pkg::DI_NEUTRAL) begin
                    ev.gear   = msq_pkg::GEAR_NEUTRAL;
                    ev.torque = 15'd0;
                end else if (i_di_word == msq_pkg::DI_SHUTDOWN) begin
                    ev.step = msq_pkg::SEQ_STOP;
                end
            end
            msq_pkg::OP_STATUS: begin
                ev.status = i_status_code;
            end
            msq_pkg::OP_TICK: begin
                if (i_state.ramp_elapsed != msq_pkg::RAMP_MAX) begin
                    ev.ramp_elapsed = i_state.ramp_elapsed + 8'd1;
                end
                if (i_state.frame_elapsed != msq_pkg::FRAME_MAX) begin
                    ev.frame_elapsed = i_state.frame_elapsed + 12'd1;
                end
            end
            default: begin
                ev = i_state;
            end
        endcase
    end

    // Sequencer next step
    always_comb begin
        seq_next = ev.step;
        case (ev.step)
            msq_pkg::SEQ_POWER: begin
                seq_next = msq_pkg::SEQ_WAIT_DIS;
            end
            msq_pkg::SEQ_WAIT_DIS: begin
                if (ev.status == i_cfg.code_disabled) seq_next = msq_pkg::SEQ_WAIT_STBY;
            end
            msq_pkg::SEQ_WAIT_STBY: begin
                if (ev.status == i_cfg.code_standby) seq_next = msq_pkg::SEQ_WAIT_EN;
            end
            msq_pkg::SEQ_WAIT_EN: begin
                if (ev.status == i_cfg.code_enabled) seq_next = msq_pkg::SEQ_RUN;
            end
            msq_pkg::SEQ_STOP: begin
                seq_next = msq_pkg::SEQ_STOP_STBY;
            end
            msq_pkg::SEQ_STOP_STBY: begin
                if (ev.status == i_cfg.code_standby) seq_next = msq_pkg::SEQ_STOP_DIS;
            end
            msq_pkg::SEQ_STOP_DIS: begin
                if (ev.status == i_cfg.code_disabled) seq_next = msq_pkg::SEQ_IDLE;
            end
            default: begin
                seq_next = ev.step;
            end
        endcase
    end

    // Sequencer actions: mode, supply and enable pulse
    always_comb begin
        mode_next   = ev.mode;
        supply_next = ev.supply_on;
        pulse       = 1'b0;
        case (ev.step)
            msq_pkg::SEQ_POWER: begin
                supply_next = 1'b1;
                pulse       = 1'b1;
            end
            msq_pkg::SEQ_WAIT_DIS: begin
                if (ev.status == i_cfg.code_disabled) mode_next = msq_pkg::MODE_STANDBY;
            end
            msq_pkg::SEQ_WAIT_STBY: begin
                if (ev.status == i_cfg.code_standby) mode_next = msq_pkg::MODE_ENABLED;
            end
            msq_pkg::SEQ_STOP: begin
                mode_next = msq_pkg::MODE_STANDBY;
            end
            msq_pkg::SEQ_STOP_STBY: begin
                if (ev.status == i_cfg.code_standby) mode_next = msq_pkg::MODE_DISABLED;
            end
            msq_pkg::SEQ_STOP_DIS: begin
                if (ev.status == i_cfg.code_disabled) supply_next = 1'b0;
            end
            default: begin
                pulse = 1'b0;
            end
        endcase
    end

    // Periodic frame check
    assign frame_due      = (ev.frame_elapsed >= i_cfg.frame_interval);
    assign frame_next     = frame_due ? 12'd0 : ev.frame_elapsed;
    assign heartbeat_next = frame_due ? (ev.heartbeat + msq_pkg::ALIVE_STEP) : ev.heartbeat;

    // Ramp one step toward the request
    assign ramp_open = (ev.ramp_elapsed >= i_cfg.ramp_interval);
    assign ramp_up   = ramp_open &&
                       ({1'b0, ev.speed} + 12'd2 <= {1'b0, ev.req_speed});
    assign ramp_down = ramp_open && !ramp_up &&
                       ({1'b0, ev.speed} >= {1'b0, ev.req_speed} + 12'd2);

    always_comb begin
        speed_next = ev.speed;
        ramp_next  = ev.ramp_elapsed;
        if (ramp_up) begin
            speed_next = ev.speed + msq_pkg::SPEED_STEP;
            ramp_next  = 8'd0;
        end else if (ramp_down) begin
            speed_next = ev.speed - msq_pkg::SPEED_STEP;
            ramp_next  = 8'd0;
        end
    end

    // Gather next state
    always_comb begin
        o_state               = ev;
        o_state.step          = seq_next;
        o_state.mode          = mode_next;
        o_state.supply_on     = supply_next;
        o_state.frame_elapsed = frame_next;
        o_state.heartbeat     = heartbeat_next;
        o_state.speed         = speed_next;
        o_state.ramp_elapsed  = ramp_next;
    end

    // Build the result item; frame words stay zero when no frame is due
    always_comb begin
        o_result.sequence_step    = seq_next;
        o_result.commanded_state  = mode_next;
        o_result.commanded_gear   = ev.gear;
        o_result.commanded_torque = ev.torque;
        o_result.ramped_speed     = speed_next;
        o_result.power_on         = supply_next;
        o_result.enable_pulse     = pulse;
        if (frame_due) begin
            o_result.speed_word        = msq_pkg::SPEED_OFFSET + {5'd0, ev.speed};
            o_result.torque_upper_word = msq_pkg::TORQUE_MID + {1'b0, ev.torque};
            o_result.torque_lower_word = msq_pkg::TORQUE_MID - {1'b0, ev.torque};
            o_result.alive_count       = ev.heartbeat;
        end else begin
            o_result.speed_word        = 16'd0;
            o_result.torque_upper_word = 16'd0;
            o_result.torque_lower_word = 16'd0;
            o_result.alive_count       = 4'd0;
        end
    end

    assign o_frame_due = frame_due;

endmodule

// ----- tb/sv/motor_seq_tracker_pkg.sv -----
// Expected-result tracker for the motor enable sequencer: state predictor plus result check.
package motor_seq_tracker_pkg;

    import msq_pkg::*;

    class motor_seq_tracker;

        // One expected result item and its frame flag
        typedef struct {
            t_result data;
            logic    due;
        } t_expected;

        t_cfg        cfg;
        t_expected   pending_results[$];
        int unsigned mismatches;
        int unsigned results_seen;

        // Predicted block state
        t_seq_step   step;
        logic [1:0]  mode;
        logic [1:0]  gear;
        logic [14:0] torque;
        logic [10:0] req_speed;
        logic [10:0] speed;
        logic [3:0]  status;
        logic [7:0]  ramp_el;
        logic [11:0] frame_el;
        logic [3:0]  heartbeat;
        logic        supply;

        function new();
            cfg          = CFG_RESET;
            step         = SEQ_IDLE;
            mode         = MODE_DISABLED;
            gear         = GEAR_NEUTRAL;
            torque       = '0;
            req_speed    = '0;
            speed        = '0;
            status       = STATUS_OFF;
            ramp_el      = RAMP_MAX;
            frame_el     = '0;
            heartbeat    = '0;
            supply       = 1'b0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        // Mirror a register write into the predicted settings
        function void set_reg(logic [2:0] addr, logic [14:0] data);
            case (addr)
                REG_RAMP_INTERVAL:  cfg.ramp_interval  = data[7:0];
                REG_FRAME_INTERVAL: cfg.frame_interval = data[11:0];
                REG_THROTTLE_LIMIT: cfg.throttle_limit = data[10:0];
                REG_DRIVE_TORQUE:   cfg.drive_torque   = data;
                REG_CODE_DISABLED:  cfg.code_disabled  = data[3:0];
                REG_CODE_STANDBY:   cfg.code_standby   = data[3:0];
                REG_CODE_ENABLED:   cfg.code_enabled   = data[3:0];
                default: ;
            endcase
        endfunction

        // Drive word: start from idle, or pick the gear while waiting for enable
        function void select_drive(logic [1:0] sel);
            if (step == SEQ_IDLE) begin
                step = SEQ_POWER;
            end else if (step == SEQ_WAIT_EN) begin
                gear   = sel;
                torque = cfg.drive_torque;
            end
        endfunction

        // Apply one accepted event and queue the result it produces
        function void note_event(t_opcode op, logic [7:0] thr, logic [15:0] di,
                                 logic [3:0] code);
            t_expected   want;
            int unsigned req;
            logic        pulse;

            want  = '{data: '0, due: 1'b0};
            pulse = 1'b0;

            // Apply the event
            case (op)
                OP_THROTTLE: begin
                    req = 4 * int'(thr);
                    if (req < cfg.throttle_limit) req_speed = req[10:0];
                end
                OP_DIGITAL: begin
                    if (di == DI_FORWARD) begin
                        select_drive(GEAR_FORWARD);
                    end else if (di == DI_REVERSE) begin
                        select_drive(GEAR_REVERSE);
                    end else if (di == DI_NEUTRAL) begin
                        gear   = GEAR_NEUTRAL;
                        torque = '0;
                    end else if (di == DI_SHUTDOWN) begin
                        step = SEQ_STOP;
                    end
                end
                OP_STATUS: status = code;
                default: begin
                    if (ramp_el != RAMP_MAX) ramp_el = ramp_el + 8'd1;
                    if (frame_el != FRAME_MAX) frame_el = frame_el + 12'd1;
                end
            endcase

            // Take one sequencer step
            case (step)
                SEQ_POWER: begin
                    supply = 1'b1;
                    pulse  = 1'b1;
                    step   = SEQ_WAIT_DIS;
                end
                SEQ_WAIT_DIS: begin
                    if (status == cfg.code_disabled) begin
                        mode = MODE_STANDBY;
                        step = SEQ_WAIT_STBY;
                    end
                end
                SEQ_WAIT_STBY: begin
                    if (status == cfg.code_standby) begin
                        mode = MODE_ENABLED;
                        step = SEQ_WAIT_EN;
                    end
                end
                SEQ_WAIT_EN: begin
                    if (status == cfg.code_enabled) step = SEQ_RUN;
                end
                SEQ_STOP: begin
                    mode = MODE_STANDBY;
                    step = SEQ_STOP_STBY;
                end
                SEQ_STOP_STBY: begin
                    if (status == cfg.code_standby) begin
                        mode = MODE_DISABLED;
                        step = SEQ_STOP_DIS;
                    end
                end
                SEQ_STOP_DIS: begin
                    if (status == cfg.code_disabled) begin
                        supply = 1'b0;
                        step   = SEQ_IDLE;
                    end
                end
                default: ;
            endcase

            // Emit the command frame, using the speed before this ramp step
            if (frame_el >= cfg.frame_interval) begin
                frame_el                    = '0;
                want.due                    = 1'b1;
                want.data.speed_word        = SPEED_OFFSET + {5'd0, speed};
                want.data.torque_upper_word = TORQUE_MID + {1'b0, torque};
                want.data.torque_lower_word = TORQUE_MID - {1'b0, torque};
                want.data.alive_count       = heartbeat;
                heartbeat                   = heartbeat + ALIVE_STEP;
            end

            // Move the ramped speed toward the request
            if (ramp_el >= cfg.ramp_interval) begin
                if (int'(speed) + 2 <= int'(req_speed)) begin
                    speed   = speed + SPEED_STEP;
                    ramp_el = '0;
                end else if (int'(speed) >= int'(req_speed) + 2) begin
                    speed   = speed - SPEED_STEP;
                    ramp_el = '0;
                end
            end

            want.data.sequence_step    = step;
            want.data.commanded_state  = mode;
            want.data.commanded_gear   = gear;
            want.data.commanded_torque = torque;
            want.data.ramped_speed     = speed;
            want.data.power_on         = supply;
            want.data.enable_pulse     = pulse;
            pending_results.push_back(want);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 100) $display("MISMATCH result %0d: %s", results_seen, msg);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        endtask

        // Compare one accepted result item with the oldest expectation
        task check_result(logic [87:0] data, logic due);
            t_result   got;
            t_expected want;

            got = t_result'(data);
            results_seen++;
            if (pending_results.size() == 0) begin
                report("result item with no expectation waiting");
                return;
            end
            want = pending_results.pop_front();
            compare_field("sequence_step", got.sequence_step, want.data.sequence_step);
            compare_field("commanded_state", got.commanded_state, want.data.commanded_state);
            compare_field("commanded_gear", got.commanded_gear, want.data.commanded_gear);
            compare_field("commanded_torque", got.commanded_torque,
                          want.data.commanded_torque);
            compare_field("ramped_speed", got.ramped_speed, want.data.ramped_speed);
            compare_field("power_on", got.power_on, want.data.power_on);
            compare_field("enable_pulse", got.enable_pulse, want.data.enable_pulse);
            compare_field("frame_due", due, want.due);
            compare_field("speed_word", got.speed_word, want.data.speed_word);
            compare_field("torque_upper_word", got.torque_upper_word,
                          want.data.torque_upper_word);
            compare_field("torque_lower_word", got.torque_lower_word,
                          want.data.torque_lower_word);
            compare_field("alive_count", got.alive_count, want.data.alive_count);
        endtask

    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// Top-level testbench of the motor enable sequencer: stimulus, handshakes and end of run.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import msq_pkg::*;
    import motor_seq_tracker_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [87:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_addr = '0;
    logic [14:0] i_cfg_data = '0;

    motor_seq_tracker tracker = new();
    int unsigned      cycles = 0;
    bit               no_idle = 1'b0;

    motor_enable_sequencer_with_ramp_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Check each accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_result(o_m_axis_tdata, o_m_axis_tuser[0]);
    end

    // Stall the result side at random before each item, unless no_idle is set
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
        end
    end

    // Send one event item; the fields it does not use carry random values
    task automatic send_event(t_opcode op, logic [15:0] value);
        logic [7:0]  thr;
        logic [15:0] di;
        logic [3:0]  code;
        int          gap;

        thr  = 8'($urandom_range(0, 255));
        di   = 16'($urandom_range(0, 65535));
        code = 4'($urandom_range(0, 15));
        case (op)
            OP_THROTTLE: thr = value[7:0];
            OP_DIGITAL:  di = value;
            OP_STATUS:   code = value[3:0];
            default: ;
        endcase
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'd0, code, di, thr};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        tracker.note_event(op, thr, di, code);
    endtask

    // Mostly well-formed traffic: configured status codes and command words
    task automatic send_random_event();
        int          pick;
        logic [15:0] value;

        pick  = $urandom_range(0, 99);
        value = 16'($urandom_range(0, 65535));
        if (pick < 35) begin
            send_event(OP_TICK, value);
        end else if (pick < 55) begin
            if ($urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 2))
                    0:       value = {12'd0, tracker.cfg.code_disabled};
                    1:       value = {12'd0, tracker.cfg.code_standby};
                    default: value = {12'd0, tracker.cfg.code_enabled};
                endcase
            end
            send_event(OP_STATUS, value);
        end else if (pick < 75) begin
            send_event(OP_THROTTLE, value);
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2: value = DI_FORWARD;
                3, 4:    value = DI_REVERSE;
                5, 6:    value = DI_NEUTRAL;
                7:       value = DI_SHUTDOWN;
                default: ;
            endcase
            send_event(OP_DIGITAL, value);
        end
    endtask

    // Hold the input until every expected result item has been taken
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.pending_count() > 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [14:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tracker.set_reg(addr, data);
    endtask

    // Write the whole register set while the block is idle
    task automatic load_settings(t_cfg c);
        write_reg(REG_RAMP_INTERVAL, {7'd0, c.ramp_interval});
        write_reg(REG_FRAME_INTERVAL, {3'd0, c.frame_interval});
        write_reg(REG_THROTTLE_LIMIT, {4'd0, c.throttle_limit});
        write_reg(REG_DRIVE_TORQUE, c.drive_torque);
        write_reg(REG_CODE_DISABLED, {11'd0, c.code_disabled});
        write_reg(REG_CODE_STANDBY, {11'd0, c.code_standby});
        write_reg(REG_CODE_ENABLED, {11'd0, c.code_enabled});
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        t_cfg setting;
        int   phase;
        int   n;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk through power-up and shutdown with reset settings
        send_event(OP_TICK, 16'd0);
        send_event(OP_STATUS, 16'hF);
        send_event(OP_THROTTLE, 16'hFF);
        send_event(OP_DIGITAL, 16'hFFFF);
        send_event(OP_DIGITAL, DI_REVERSE);
        send_event(OP_DIGITAL, DI_FORWARD);
        send_event(OP_STATUS, 16'd1);
        send_event(OP_STATUS, 16'd3);
        send_event(OP_STATUS, 16'd2);
        send_event(OP_DIGITAL, DI_FORWARD);
        send_event(OP_DIGITAL, DI_REVERSE);
        send_event(OP_STATUS, 16'd3);
        send_event(OP_TICK, 16'd0);
        send_event(OP_TICK, 16'd0);
        send_event(OP_TICK, 16'd0);
        send_event(OP_DIGITAL, DI_NEUTRAL);
        send_event(OP_THROTTLE, 16'h00);
        send_event(OP_DIGITAL, DI_SHUTDOWN);
        send_event(OP_STATUS, 16'd2);
        send_event(OP_STATUS, 16'd1);
        send_event(OP_DIGITAL, DI_SHUTDOWN);
        send_event(OP_STATUS, 16'd0);
        send_event(OP_TICK, 16'd0);
        drain_results();

        // Random traffic under low extremes, high extremes, then random settings
        for (phase = 0; phase < 8; phase++) begin
            if (phase == 0) begin
                setting = '{ramp_interval: 8'd1, frame_interval: 12'd1,
                            throttle_limit: 11'd0, drive_torque: 15'd0,
                            code_disabled: 4'd0, code_standby: 4'd0,
                            code_enabled: 4'd0};
            end else if (phase == 1) begin
                setting = '{ramp_interval: 8'd255, frame_interval: 12'd4095,
                            throttle_limit: 11'd2047, drive_torque: 15'd30000,
                            code_disabled: 4'd15, code_standby: 4'd15,
                            code_enabled: 4'd15};
            end else begin
                setting.ramp_interval  = 8'($urandom_range(1, 8));
                setting.frame_interval = 12'($urandom_range(1, 40));
                setting.throttle_limit = 11'($urandom_range(0, 2047));
                setting.drive_torque   = 15'($urandom_range(0, 30000));
                setting.code_disabled  = 4'($urandom_range(0, 15));
                setting.code_standby   = 4'($urandom_range(0, 15));
                setting.code_enabled   = 4'($urandom_range(0, 15));
            end
            load_settings(setting);
            for (n = 0; n < 108; n++) begin
                if (n % 36 == 0) no_idle = ($urandom_range(0, 3) == 0);
                if (n == 54) drain_results();
                send_random_event();
            end
            drain_results();
        end

        repeat (4) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/msq_pkg.sv
rtl/msq_step.sv
rtl/motor_enable_sequencer_with_ramp_core.sv
tb/sv/motor_seq_tracker_pkg.sv
tb/sv/tb_top.sv
